// ===== sv/assert_macros.svh =====
// Assertion helpers shared by the RTL. Both forms collapse to nothing in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(prop)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, prop, msg)
`endif
`endif

// ===== sv/dps_pkg.sv =====
package dps_pkg;

   localparam int TEMP_W  = 20;
   localparam int PRES_W  = 20;
   localparam int TIME_W  = 32;
   localparam int DB_W    = 16;
   localparam int MIN_W   = 10;
   localparam int GAIN_W  = 16;
   localparam int LINK_W  = 3;
   localparam int DUR_W   = 16;
   localparam int QUO_W   = 20;
   localparam int NUM_W   = DUR_W + QUO_W;
   localparam int CNT_W   = $clog2(QUO_W + 1);
   localparam int E_W     = 22;
   localparam int SUM_W   = 22;
   localparam int MUL_W   = 32;
   localparam int PROD_W  = 2 * MUL_W;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 20;

   localparam logic [CSR_IDX_W-1:0] CSR_DEADBAND     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_PRESSURE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_PRESSURE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RAMP_OFFSET  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RAMP_MINUTES = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN         = 3'd5;

   localparam logic [MUL_W-1:0]  SEC_PER_MIN = 32'd60;
   localparam logic [SUM_W-1:0]  GAIN_CAP    = 22'h20_0000;
   localparam logic [PRES_W-1:0] MAX_PRES_RESET = 20'hF_FFFF;

   typedef struct packed {
      logic [TEMP_W-1:0] temperature;
      logic [TEMP_W-1:0] setpoint;
      logic [TIME_W-1:0] now_seconds;
      logic [PRES_W-1:0] base_pressure;
      logic [LINK_W-1:0] link_invalid;
   } req_type;

   typedef struct packed {
      logic [PRES_W-1:0] pressure;
      logic [TIME_W-1:0] ramp_start_out;
      logic              status;
   } rsp_type;

   typedef struct packed {
      logic start;
   } div_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DUR,
      ST_GAIN,
      ST_SQ,
      ST_RMUL,
      ST_DIVGO,
      ST_DIV,
      ST_ABOVE,
      ST_SUM,
      ST_FIN
   } state_type;

   typedef enum logic [1:0] {
      RG_MIN,
      RG_BASE,
      RG_BAND,
      RG_ABOVE
   } region_type;

endpackage

// ===== sv/deadband_pressure_setpoint_core.sv =====
// Deadband pressure setpoint core.
// The req channel carries one temperature sample per transaction (temperature,
// setpoint, time, base pressure, link alarm flags); the rsp channel returns one
// pressure demand, the ramp start time and a status bit for each of them.
// Both channels use valid/stall; a transaction completes when valid is high and
// stall is low. The csr port writes the six setting registers by index; write it
// only while no sample is in flight.
// A valid sample runs through the sequencer steps, and the core takes no new
// sample until the last one has been loaded into the output register. The steps
// are built around one shared 32x32 multiplier (four products) and
// the 20-step restoring divider that scales the ramp. A sample with a link alarm
// set skips straight to the final step, which loads the output register.
// The result sits in an output register; while the receiver stalls it holds,
// and the core can still take the next sample and work on it, only waiting at
// the final step until the output register is free.
// Reset is synchronous: the setting registers return to their defaults (the
// maximum pressure to full scale, everything else to zero) and the ramp start
// time to zero.
module deadband_pressure_setpoint_core
   import dps_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_payload,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

`include "assert_macros.svh"

   logic [DB_W-1:0]   deadband_ff;
   logic [PRES_W-1:0] min_pressure_ff;
   logic [PRES_W-1:0] max_pressure_ff;
   logic [PRES_W-1:0] ramp_offset_ff;
   logic [MIN_W-1:0]  ramp_minutes_ff;
   logic [GAIN_W-1:0] gain_ff;
   logic [TIME_W-1:0] ramp_start_ff;

   state_type         state_ff, state_in;
   req_type           req_ff;
   logic              invalid_ff;
   logic signed [E_W-1:0] err_ff;
   region_type        region_ff;
   logic [PRES_W-1:0] excess_ff;
   logic [TIME_W-1:0] elapsed_ff;
   logic [DUR_W-1:0]  dur_ff;
   logic [DUR_W-1:0]  rem_t_ff;
   logic              ramp_en_ff;
   logic              xsat_ff;
   logic [SUM_W-1:0]  g_ff;
   logic [PRES_W-1:0] ramp_ff;
   logic [SUM_W-1:0]  above_ff;
   logic [SUM_W-1:0]  sum_ff;
   logic [PROD_W-1:0] mul_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff;

   logic              req_accept;
   logic signed [E_W-1:0] err_in;
   logic signed [E_W-1:0] db_s;
   logic              out_of_band;
   logic [MUL_W-1:0]  mul_a;
   logic [MUL_W-1:0]  mul_b;
   div_ctrl_type      div_ctrl;
   div_stat_type      div_stat;
   logic [QUO_W-1:0]  div_q;
   logic              rsp_load;
   logic [DUR_W-1:0]  dur_now;
   logic [MUL_W-1:0]  sq_hi;
   logic [SUM_W-1:0]  base_g;
   logic [PRES_W-1:0] lo_lim;
   logic [PRES_W-1:0] hi_lim;
   logic [PRES_W-1:0] p_clamped;
   rsp_type           rsp_in;

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = (state_ff != ST_IDLE);

   always_comb begin
      err_in = $signed({2'b00, req_payload.temperature})
             - $signed({2'b00, req_payload.setpoint});
      db_s   = $signed({{(E_W-DB_W){1'b0}}, deadband_ff});
      out_of_band = (err_in > db_s) || (err_in < -db_s);
   end

   // Settings.
   always_ff @(posedge clock) begin
      if (reset) begin
         deadband_ff     <= '0;
         min_pressure_ff <= '0;
         max_pressure_ff <= MAX_PRES_RESET;
         ramp_offset_ff  <= '0;
         ramp_minutes_ff <= '0;
         gain_ff         <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_DEADBAND:     deadband_ff     <= csr_data[DB_W-1:0];
            CSR_MIN_PRESSURE: min_pressure_ff <= csr_data[PRES_W-1:0];
            CSR_MAX_PRESSURE: max_pressure_ff <= csr_data[PRES_W-1:0];
            CSR_RAMP_OFFSET:  ramp_offset_ff  <= csr_data[PRES_W-1:0];
            CSR_RAMP_MINUTES: ramp_minutes_ff <= csr_data[MIN_W-1:0];
            CSR_GAIN:         gain_ff         <= csr_data[GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   // The ramp restarts as soon as the sample leaves the deadband, so the rest
   // of the sequence already sees the new start time.
   always_ff @(posedge clock) begin
      if (reset) begin
         ramp_start_ff <= '0;
      end else if (req_accept && req_payload.link_invalid == '0 && out_of_band) begin
         ramp_start_ff <= req_payload.now_seconds;
      end
   end

   // Sequencer.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = (req_payload.link_invalid != '0) ? ST_FIN : ST_DUR;
            end
         end
         ST_DUR:   state_in = ST_GAIN;
         ST_GAIN:  state_in = ST_SQ;
         ST_SQ:    state_in = ST_RMUL;
         ST_RMUL:  state_in = ST_DIVGO;
         ST_DIVGO: state_in = ST_DIV;
         ST_DIV: begin
            if (div_stat.done) begin
               state_in = ST_ABOVE;
            end
         end
         ST_ABOVE: state_in = ST_SUM;
         ST_SUM:   state_in = ST_FIN;
         ST_FIN: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      mul_a          = '0;
      mul_b          = '0;
      div_ctrl.start = 1'b0;
      rsp_load       = 1'b0;
      unique case (state_ff)
         ST_DUR: begin
            mul_a = MUL_W'(ramp_minutes_ff);
            mul_b = SEC_PER_MIN;
         end
         ST_GAIN: begin
            mul_a = MUL_W'(excess_ff);
            mul_b = MUL_W'(gain_ff);
         end
         ST_SQ: begin
            mul_a = mul_ff[MUL_W-1:0];
            mul_b = mul_ff[MUL_W-1:0];
         end
         ST_RMUL: begin
            mul_a = MUL_W'(ramp_offset_ff);
            mul_b = ramp_en_ff ? MUL_W'(rem_t_ff) : '0;
         end
         ST_DIVGO: div_ctrl.start = 1'b1;
         ST_FIN:   rsp_load = !rsp_valid_ff || !rsp_stall;
         default: ;
      endcase
   end

   // Shared multiplier with its product register.
   always_ff @(posedge clock) begin
      mul_ff <= mul_a * mul_b;
   end

   dps_div u_div (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (div_ctrl),
      .num      (mul_ff[NUM_W-1:0]),
      .den      (dur_ff),
      .stat     (div_stat),
      .quotient (div_q)
   );

   always_comb begin
      dur_now = mul_ff[DUR_W-1:0];
      sq_hi   = mul_ff[PROD_W-1:MUL_W];
      base_g  = SUM_W'(req_ff.base_pressure) + g_ff;
   end

   // Datapath registers, each loaded in its own step of the sequence.
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               req_ff     <= req_payload;
               invalid_ff <= (req_payload.link_invalid != '0);
               err_ff     <= err_in;
            end
         end
         ST_DUR: begin
            elapsed_ff <= req_ff.now_seconds - ramp_start_ff;
            excess_ff  <= PRES_W'(err_ff - db_s);
            if (err_ff <= -(db_s <<< 1)) begin
               region_ff <= RG_MIN;
            end else if (err_ff <= -db_s) begin
               region_ff <= RG_BASE;
            end else if (err_ff <= db_s) begin
               region_ff <= RG_BAND;
            end else begin
               region_ff <= RG_ABOVE;
            end
         end
         ST_GAIN: begin
            dur_ff     <= dur_now;
            ramp_en_ff <= (dur_now != '0) && (elapsed_ff < TIME_W'(dur_now));
            rem_t_ff   <= dur_now - elapsed_ff[DUR_W-1:0];
         end
         ST_SQ: begin
            xsat_ff <= (sq_hi != '0);
         end
         ST_RMUL: begin
            if (xsat_ff || sq_hi > MUL_W'(GAIN_CAP)) begin
               g_ff <= GAIN_CAP;
            end else begin
               g_ff <= sq_hi[SUM_W-1:0];
            end
         end
         ST_DIV: begin
            if (div_stat.done) begin
               ramp_ff <= ramp_en_ff ? div_q : '0;
            end
         end
         ST_ABOVE: begin
            if (req_ff.base_pressure >= max_pressure_ff) begin
               above_ff <= SUM_W'(req_ff.base_pressure);
            end else if (base_g > SUM_W'(max_pressure_ff)) begin
               above_ff <= SUM_W'(max_pressure_ff);
            end else begin
               above_ff <= base_g;
            end
         end
         ST_SUM: begin
            case (region_ff)
               RG_MIN:  sum_ff <= SUM_W'(min_pressure_ff);
               RG_BASE: sum_ff <= SUM_W'(req_ff.base_pressure);
               RG_BAND: sum_ff <= SUM_W'(req_ff.base_pressure) + SUM_W'(ramp_ff);
               default: sum_ff <= above_ff + SUM_W'(ramp_ff);
            endcase
         end
         default: ;
      endcase
   end

   // Final clamp; the limits may have been written in either order.
   always_comb begin
      if (min_pressure_ff <= max_pressure_ff) begin
         lo_lim = min_pressure_ff;
         hi_lim = max_pressure_ff;
      end else begin
         lo_lim = max_pressure_ff;
         hi_lim = min_pressure_ff;
      end
      if (sum_ff < SUM_W'(lo_lim)) begin
         p_clamped = lo_lim;
      end else if (sum_ff > SUM_W'(hi_lim)) begin
         p_clamped = hi_lim;
      end else begin
         p_clamped = sum_ff[PRES_W-1:0];
      end
      rsp_in.pressure       = invalid_ff ? '0 : p_clamped;
      rsp_in.ramp_start_out = ramp_start_ff;
      rsp_in.status         = invalid_ff;
   end

   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `ASSERT_CLK(a_alarm_zero, clock, reset, rsp_valid && rsp_payload.status |-> rsp_payload.pressure == '0, "alarm transaction carries nonzero pressure")
   `ASSERT_CLK(a_clamped, clock, reset, rsp_valid && !rsp_payload.status |-> (rsp_payload.pressure >= min_pressure_ff || rsp_payload.pressure >= max_pressure_ff) && (rsp_payload.pressure <= min_pressure_ff || rsp_payload.pressure <= max_pressure_ff), "pressure outside the limits")
   `ASSERT_NEVER(a_div_owned, clock, reset, div_stat.busy && state_ff != ST_DIV, "divider busy outside its step")
   `ASSERT_CLK(a_ramp_hold, clock, reset, !$past(reset) && !$stable(ramp_start_ff) |-> $past(req_accept), "ramp start moved without a transaction")

endmodule

// ===== sv/dps_div.sv =====
module dps_div
   import dps_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  div_ctrl_type       ctrl,
   input  logic [NUM_W-1:0]   num,
   input  logic [DUR_W-1:0]   den,
   output div_stat_type       stat,
   output logic [QUO_W-1:0]   quotient
);

   logic [DUR_W-1:0] rem_ff;
   logic [QUO_W-1:0] sh_ff;
   logic [DUR_W-1:0] den_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;

   logic [DUR_W:0]   rem_sh;
   logic             fits;
   logic [DUR_W:0]   rem_sub;

   // One quotient bit per cycle; dividend bits shift out of the top of sh_ff
   // while quotient bits shift in at the bottom.
   always_comb begin
      rem_sh  = {rem_ff, sh_ff[QUO_W-1]};
      fits    = rem_sh >= {1'b0, den_ff};
      rem_sub = rem_sh - {1'b0, den_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (ctrl.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(QUO_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.start) begin
         rem_ff <= num[NUM_W-1:QUO_W];
         sh_ff  <= num[QUO_W-1:0];
         den_ff <= den;
      end else if (busy_ff) begin
         rem_ff <= fits ? rem_sub[DUR_W-1:0] : rem_sh[DUR_W-1:0];
         sh_ff  <= {sh_ff[QUO_W-2:0], fits};
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = sh_ff;

endmodule

// ===== bench/pressure_demand_checker.sv =====
`timescale 1ns / 1ps

module pressure_demand_checker
   import dps_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  req_type               req_payload,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  rsp_type               rsp_payload,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output int                    fail_count,
   output int                    open_count
);

   // Shadow copy of the settings and of the ramp start time.
   logic [DB_W-1:0]   db_mk;
   logic [PRES_W-1:0] floor_pres;
   logic [PRES_W-1:0] ceil_pres;
   logic [PRES_W-1:0] boost_pres;
   logic [MIN_W-1:0]  boost_minutes;
   logic [GAIN_W-1:0] gain_q16;
   logic [TIME_W-1:0] ramp_origin;

   rsp_type demand_queue[$];

   function automatic void flag_error(string what, longint unsigned want,
                                      longint unsigned got);
      fail_count++;
      if (fail_count <= 10) begin
         $display("%0t: %s mismatch: expected %0h, got %0h", $time, what, want, got);
      end
   endfunction

   // Limits given in the wrong order still clamp to the interval between them.
   function automatic longint clamp_span(longint v, longint a, longint b);
      longint lo, hi;
      lo = (a < b) ? a : b;
      hi = (a < b) ? b : a;
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic rsp_type predict_demand(req_type s);
      rsp_type           r;
      longint            band, temp_mk, set_mk, err, base, ramp, p, g;
      longint            floor_lim, ceil_lim;
      longint unsigned   span, elapsed, boost, excess, x;
      logic [TIME_W-1:0] lapse;
      r = '0;
      if (s.link_invalid != '0) begin
         r.ramp_start_out = ramp_origin;
         r.status = 1'b1;
         return r;
      end
      band = db_mk;
      temp_mk = s.temperature;
      set_mk = s.setpoint;
      base = s.base_pressure;
      floor_lim = floor_pres;
      ceil_lim = ceil_pres;
      err = temp_mk - set_mk;
      if (err > band || err < -band) ramp_origin = s.now_seconds;

      // The elapsed time wraps, so a clock running backwards ends the ramp.
      lapse = s.now_seconds - ramp_origin;
      elapsed = lapse;
      span = boost_minutes;
      span = span * 60;
      boost = boost_pres;
      ramp = 0;
      if (span != 0 && elapsed < span) ramp = (boost * (span - elapsed)) / span;

      if (err <= -2 * band) begin
         p = floor_lim;
      end else if (err <= -band) begin
         p = base;
      end else if (err <= band) begin
         p = base + ramp;
      end else begin
         excess = err - band;
         x = excess * gain_q16;
         if (x >= 64'h1_0000_0000) begin
            g = GAIN_CAP;
         end else begin
            g = (x * x) >> 32;
            if (g > GAIN_CAP) g = GAIN_CAP;
         end
         p = clamp_span(base + g, base, ceil_lim) + ramp;
      end
      p = clamp_span(p, floor_lim, ceil_lim);
      r.pressure = p[PRES_W-1:0];
      r.ramp_start_out = ramp_origin;
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         db_mk = '0;
         floor_pres = '0;
         ceil_pres = MAX_PRES_RESET;
         boost_pres = '0;
         boost_minutes = '0;
         gain_q16 = '0;
         ramp_origin = '0;
         demand_queue.delete();
         fail_count = 0;
         open_count <= 0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_DEADBAND:     db_mk = csr_data[DB_W-1:0];
               CSR_MIN_PRESSURE: floor_pres = csr_data[PRES_W-1:0];
               CSR_MAX_PRESSURE: ceil_pres = csr_data[PRES_W-1:0];
               CSR_RAMP_OFFSET:  boost_pres = csr_data[PRES_W-1:0];
               CSR_RAMP_MINUTES: boost_minutes = csr_data[MIN_W-1:0];
               CSR_GAIN:         gain_q16 = csr_data[GAIN_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (demand_queue.size() == 0) begin
               flag_error("unexpected transaction, pressure", 0, rsp_payload.pressure);
            end else begin
               want = demand_queue.pop_front();
               if (rsp_payload.pressure !== want.pressure)
                  flag_error("pressure", want.pressure, rsp_payload.pressure);
               if (rsp_payload.ramp_start_out !== want.ramp_start_out)
                  flag_error("ramp_start_out", want.ramp_start_out,
                             rsp_payload.ramp_start_out);
               if (rsp_payload.status !== want.status)
                  flag_error("status", want.status, rsp_payload.status);
            end
         end
         if (req_valid && !req_stall) demand_queue.push_back(predict_demand(req_payload));
         open_count <= demand_queue.size();
      end
   end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
   import dps_pkg::*;

   localparam int PHASES       = 8;
   localparam int PHASE_ITEMS  = 204;
   localparam int LIMIT_CYCLES = 600000;
   localparam int FIELD_MAX    = (1 << TEMP_W) - 1;

   logic                  clock;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_stall;
   req_type               req_payload = '0;
   logic                  rsp_valid;
   logic                  rsp_stall   = 1'b0;
   rsp_type               rsp_payload;
   logic                  csr_write   = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index   = '0;
   logic [CSR_DATA_W-1:0] csr_data    = '0;

   int                fail_count;
   int                open_count;
   int                gap_odds     = 0;
   int                stall_odds   = 0;
   int                stall_left   = 0;
   int                cur_deadband = 0;
   int unsigned       cycles       = 0;
   logic [TIME_W-1:0] wall         = '0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   deadband_pressure_setpoint_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   pressure_demand_checker i_check (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .fail_count  (fail_count),
      .open_count  (open_count)
   );

   // Receiver back-pressure comes in random bursts.
   always @(posedge clock) begin
      if (reset || stall_odds == 0) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else if ($urandom_range(1, stall_odds) == 1) begin
         rsp_stall <= 1'b1;
         stall_left = $urandom_range(0, 13);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == LIMIT_CYCLES) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
   endtask

   task automatic program_settings(input int db, input int lo, input int hi,
                                   input int offs, input int mins, input int gn);
      write_csr(CSR_DEADBAND, CSR_DATA_W'(db));
      write_csr(CSR_MIN_PRESSURE, CSR_DATA_W'(lo));
      write_csr(CSR_MAX_PRESSURE, CSR_DATA_W'(hi));
      write_csr(CSR_RAMP_OFFSET, CSR_DATA_W'(offs));
      write_csr(CSR_RAMP_MINUTES, CSR_DATA_W'(mins));
      write_csr(CSR_GAIN, CSR_DATA_W'(gn));
      csr_write <= 1'b0;
      cur_deadband = db;
   endtask

   // Holds off the sender until every outstanding transaction has returned.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (open_count != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic send_fields(input logic [TEMP_W-1:0] temp, input logic [TEMP_W-1:0] sp,
                              input logic [TIME_W-1:0] now, input logic [PRES_W-1:0] base,
                              input logic [LINK_W-1:0] links);
      req_type t;
      t.temperature = temp;
      t.setpoint = sp;
      t.now_seconds = now;
      t.base_pressure = base;
      t.link_invalid = links;
      if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= t;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Errors cluster around the region borders at minus two, minus one and plus one deadbands.
   task automatic send_random_item();
      int                span, err, sp;
      logic [PRES_W-1:0] base;
      logic [LINK_W-1:0] links;
      span = 3 * cur_deadband + 3;
      case ($urandom_range(0, 9))
         0: err = int'($urandom_range(0, FIELD_MAX)) - int'($urandom_range(0, FIELD_MAX));
         9: begin
            case ($urandom_range(0, 5))
               0: err = -2 * cur_deadband;
               1: err = -2 * cur_deadband + 1;
               2: err = -cur_deadband;
               3: err = -cur_deadband + 1;
               4: err = cur_deadband;
               default: err = cur_deadband + 1;
            endcase
         end
         default: err = int'($urandom_range(0, 2 * span)) - span;
      endcase
      if (err >= 0) sp = $urandom_range(0, FIELD_MAX - err);
      else sp = $urandom_range(-err, FIELD_MAX);
      case ($urandom_range(0, 19))
         0: wall = $urandom;
         1: wall = wall - $urandom_range(1, 600);
         2: wall = wall + $urandom_range(0, 70000);
         default: wall = wall + $urandom_range(0, 25);
      endcase
      case ($urandom_range(0, 9))
         0: base = '0;
         1: base = '1;
         default: base = PRES_W'($urandom_range(0, FIELD_MAX));
      endcase
      links = ($urandom_range(0, 11) == 0) ? LINK_W'($urandom_range(1, 7)) : '0;
      send_fields(TEMP_W'(sp + err), TEMP_W'(sp), wall, base, links);
   endtask

   initial begin
      int phase;
      int n;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Deadband 1000 mK, two minute ramp: walk across every region border.
      program_settings(1000, 5000, 900000, 40000, 2, 3000);
      gap_odds = 4;
      stall_odds = 5;
      send_fields(20'hFFFFF, 20'h00000, 32'hFFFF_FFFF, 20'hFFFFF, 3'b111);
      send_fields(500000, 500000, 100, 300000, 3'b001);
      send_fields(500000, 500000, 100, 300000, 3'b010);
      send_fields(500000, 500000, 100, 300000, 3'b100);
      send_fields(20'h00000, 20'hFFFFF, 1000, 20'h00000, 3'b000);
      send_fields(498000, 500000, 1010, 300000, 3'b000);
      send_fields(498001, 500000, 1020, 300000, 3'b000);
      send_fields(499000, 500000, 1030, 300000, 3'b000);
      send_fields(499001, 500000, 1040, 300000, 3'b000);
      send_fields(500000, 500000, 1140, 300000, 3'b000);
      send_fields(501000, 500000, 1000, 300000, 3'b000);
      send_fields(501001, 500000, 2000, 300000, 3'b000);
      send_fields(20'hFFFFF, 20'h00000, 2050, 100000, 3'b000);
      send_fields(530000, 500000, 2060, 200000, 3'b000);
      send_fields(501005, 500000, 2070, 20'hFFFFF, 3'b000);
      send_fields(20'h00000, 20'h00000, 32'h0000_0000, 20'h00000, 3'b000);
      send_fields(400000, 400000, 32'hFFFF_FFFF, 250000, 3'b000);
      send_fields(20'hFFFFF, 20'hFFFFF, 32'h8000_0000, 20'hFFFFF, 3'b000);
      wait_drained();

      // Minimum above maximum, and a zero ramp duration.
      program_settings(300, 800000, 100000, 50000, 0, 500);
      send_fields(600000, 600000, 5000, 300000, 3'b000);
      send_fields(599500, 600000, 5010, 50000, 3'b000);
      send_fields(599300, 600000, 5020, 900000, 3'b000);
      send_fields(610000, 600000, 5030, 20000, 3'b000);

      for (phase = 0; phase < PHASES; phase++) begin
         wait_drained();
         case (phase)
            0: program_settings(65535, 0, FIELD_MAX, FIELD_MAX, 1023, 65535);
            1: program_settings(0, 0, FIELD_MAX, $urandom_range(0, FIELD_MAX), 1,
                                $urandom_range(0, 65535));
            2: program_settings($urandom_range(1, 3000), $urandom_range(600000, FIELD_MAX),
                                $urandom_range(0, 400000), $urandom_range(0, FIELD_MAX), 0,
                                $urandom_range(0, 65535));
            3: program_settings($urandom_range(0, 65535), FIELD_MAX, 0,
                                $urandom_range(0, FIELD_MAX), $urandom_range(0, 1023),
                                $urandom_range(0, 65535));
            default: program_settings($urandom_range(1, 3000), $urandom_range(0, 200000),
                                      $urandom_range(300000, FIELD_MAX),
                                      $urandom_range(0, FIELD_MAX), $urandom_range(0, 30),
                                      $urandom_range(0, 65535));
         endcase
         if (phase == PHASES - 1) begin
            gap_odds = 0;
            stall_odds = 0;
         end else begin
            case (phase % 3)
               0: begin
                  gap_odds = 3;
                  stall_odds = 6;
               end
               1: begin
                  gap_odds = 0;
                  stall_odds = 0;
               end
               default: begin
                  gap_odds = 8;
                  stall_odds = 3;
               end
            endcase
         end
         for (n = 0; n < PHASE_ITEMS; n++) begin
            send_random_item();
            if (phase != PHASES - 1 && $urandom_range(0, 149) == 0) wait_drained();
         end
      end

      wait_drained();
      repeat (40) @(posedge clock);
      if (fail_count == 0 && open_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
